[src/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

    localparam int LENGTH_BITS = 64;

    // Largest accepted payload length; bit 63 is never allowed.
    localparam logic [63:0] LEN_LIMIT = (LENGTH_BITS >= 64) ? 64'h7fff_ffff_ffff_ffff
                                        : ((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    localparam logic [3:0] VERDICT_NONE      = 4'd0;
    localparam logic [3:0] VERDICT_TEXT      = 4'd1;
    localparam logic [3:0] VERDICT_BINARY    = 4'd2;
    localparam logic [3:0] VERDICT_CLOSE     = 4'd3;
    localparam logic [3:0] VERDICT_PING      = 4'd4;
    localparam logic [3:0] VERDICT_PONG      = 4'd5;
    localparam logic [3:0] VERDICT_UNKNOWN   = 4'd6;
    localparam logic [3:0] VERDICT_ERR_FRAG  = 4'd7;
    localparam logic [3:0] VERDICT_ERR_CONT  = 4'd8;
    localparam logic [3:0] VERDICT_ERR_LEN   = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic [3:0] message_opcode;
        logic       last_of_frame;
        logic       last_of_message;
        logic [3:0] verdict;
    } res_t;

endpackage

[src/wsd_parser.sv]
// Frame header parser, payload unmasking and fragment tracking.
// One byte is consumed per step; the result is combinational. Uses wsd_pkg.
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    output logic       res_valid,
    output res_t       res
);

    localparam logic [3:0] PH_FIRST     = 4'd0;
    localparam logic [3:0] PH_SECOND    = 4'd1;
    localparam logic [3:0] PH_EXT64     = 4'd2;
    localparam logic [3:0] PH_EXT16     = 4'd8;
    localparam logic [3:0] PH_EXT_LAST  = 4'd9;
    localparam logic [3:0] PH_MASK      = 4'd10;
    localparam logic [3:0] PH_MASK_LAST = 4'd13;
    localparam logic [3:0] PH_PAYLOAD   = 4'd14;

    logic [3:0]  phase_reg, phase_next;
    logic        final_reg, final_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [6:0]  len_code_reg, len_code_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  pos_reg, pos_next;
    logic [3:0]  held_reg, held_next;
    logic        pending_reg, pending_next;
    logic        closed_reg, closed_next;

    logic        fin_go;
    logic [63:0] fin_len;
    logic        end_go;
    logic        end_has;
    logic [7:0]  end_data;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic [3:0]  eff;
    logic [3:0]  err;

    function automatic logic [3:0] verdict_of(input logic [3:0] op);
        logic [3:0] v;
        unique case (op)
            OP_TEXT:  v = VERDICT_TEXT;
            OP_BIN:   v = VERDICT_BINARY;
            OP_CLOSE: v = VERDICT_CLOSE;
            OP_PING:  v = VERDICT_PING;
            OP_PONG:  v = VERDICT_PONG;
            default:  v = VERDICT_UNKNOWN;
        endcase
        return v;
    endfunction

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign plain = byte_in ^ key_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        final_next    = final_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        len_code_next = len_code_reg;
        remain_next   = remain_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        held_next     = held_reg;
        pending_next  = pending_reg;
        closed_next   = closed_reg;
        res_valid     = 1'b0;
        res           = '0;
        fin_go        = 1'b0;
        fin_len       = remain_reg;
        end_go        = 1'b0;
        end_has       = 1'b0;
        end_data      = 8'd0;
        eff           = OP_CONT;
        err           = VERDICT_NONE;

        if (step && !closed_reg)
        begin
            if (phase_reg == PH_FIRST)
            begin
                final_next  = byte_in[7];
                opcode_next = byte_in[3:0];
                key_next    = '0;
                pos_next    = '0;
                remain_next = '0;
                phase_next  = PH_SECOND;
            end
            else if (phase_reg == PH_SECOND)
            begin
                masked_next   = byte_in[7];
                len_code_next = byte_in[6:0];
                if (byte_in[6:0] < 7'd126)
                begin
                    remain_next = {57'd0, byte_in[6:0]};
                    if (byte_in[7])
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        fin_go  = 1'b1;
                        fin_len = {57'd0, byte_in[6:0]};
                    end
                end
                else
                begin
                    phase_next = (byte_in[6:0] == 7'd126) ? PH_EXT16 : PH_EXT64;
                end
            end
            else if (phase_reg >= PH_EXT64 && phase_reg <= PH_EXT_LAST)
            begin
                remain_next = {remain_reg[55:0], byte_in};
                if (phase_reg == PH_EXT_LAST)
                begin
                    if (masked_reg)
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        fin_go  = 1'b1;
                        fin_len = {remain_reg[55:0], byte_in};
                    end
                end
                else
                begin
                    phase_next = phase_reg + 4'd1;
                end
            end
            else if (phase_reg >= PH_MASK && phase_reg <= PH_MASK_LAST)
            begin
                key_next = {key_reg[23:0], byte_in};
                if (phase_reg == PH_MASK_LAST)
                begin
                    fin_go  = 1'b1;
                    fin_len = remain_reg;
                end
                else
                begin
                    phase_next = phase_reg + 4'd1;
                end
            end
            else if (phase_reg == PH_PAYLOAD)
            begin
                pos_next    = pos_reg + 2'd1;
                remain_next = remain_reg - 64'd1;
                if (remain_reg == 64'd1)
                begin
                    end_go   = 1'b1;
                    end_has  = 1'b1;
                    end_data = plain;
                end
                else
                begin
                    res_valid          = 1'b1;
                    res.data_byte      = plain;
                    res.has_data       = 1'b1;
                    res.message_opcode = (opcode_reg != OP_CONT) ? opcode_reg : held_reg;
                end
            end
            else
            begin
                phase_next = PH_FIRST;
            end

            // header complete: error checks, then fragment bookkeeping
            if (fin_go)
            begin
                phase_next = PH_FIRST;
                if (fin_len > LEN_LIMIT)
                    err = VERDICT_ERR_LEN;
                else if (opcode_reg != OP_CONT && pending_reg)
                    err = VERDICT_ERR_FRAG;
                else if (opcode_reg == OP_CONT && !pending_reg)
                    err = VERDICT_ERR_CONT;

                if (err != VERDICT_NONE)
                begin
                    closed_next         = 1'b1;
                    res_valid           = 1'b1;
                    res.message_opcode  = opcode_reg;
                    res.last_of_frame   = 1'b1;
                    res.last_of_message = final_reg;
                    res.verdict         = err;
                end
                else
                begin
                    if (!final_reg && opcode_reg != OP_CONT)
                    begin
                        held_next    = opcode_reg;
                        pending_next = 1'b1;
                    end
                    if (fin_len == 64'd0)
                        end_go = 1'b1;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end

            if (end_go)
            begin
                eff        = (opcode_reg != OP_CONT) ? opcode_reg : held_next;
                phase_next = PH_FIRST;
                if (final_reg)
                begin
                    res.verdict  = verdict_of(eff);
                    pending_next = 1'b0;
                    if (eff == OP_CLOSE)
                        closed_next = 1'b1;
                end
                res_valid           = 1'b1;
                res.data_byte       = end_data;
                res.has_data        = end_has;
                res.message_opcode  = eff;
                res.last_of_frame   = 1'b1;
                res.last_of_message = final_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIRST;
            final_reg    <= 1'b0;
            opcode_reg   <= OP_CONT;
            masked_reg   <= 1'b0;
            len_code_reg <= '0;
            remain_reg   <= '0;
            key_reg      <= '0;
            pos_reg      <= '0;
            held_reg     <= OP_CONT;
            pending_reg  <= 1'b0;
            closed_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            final_reg    <= final_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            len_code_reg <= len_code_next;
            remain_reg   <= remain_next;
            key_reg      <= key_next;
            pos_reg      <= pos_next;
            held_reg     <= held_next;
            pending_reg  <= pending_next;
            closed_reg   <= closed_next;
        end
    end

`ifndef ASSERT_OFF
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("link closed flag cleared");

    a_no_result_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (step && closed_reg) |-> !res_valid)
        else $error("result produced after close");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remain_reg != 64'd0))
        else $error("payload phase with zero bytes left");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.has_data) |-> res.last_of_frame)
        else $error("empty result not at frame end");
`endif

endmodule

[src/wsd_out_reg.sv]
// Result register for the deframer output channel.
// Holds one result until the downstream transaction completes. Uses wsd_pkg.
module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       res_valid,
    input  res_t       res,
    input  logic       out_ready,
    output logic       out_valid,
    output res_t       out_res
);

    logic valid_reg, valid_next;
    res_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[src/websocket_frame_deframer.sv]
// Receive-side WebSocket frame deframer: takes one stream byte per transaction and gives at
// most one result per byte (unmasked payload byte and/or end-of-frame verdict). It sustains
// one byte per clock while out_ready stays high; a byte is held in the input register, then
// its result in the output register. The pace is set by the single pass through the parser,
// whose longest path is the 64-bit payload-remaining decrement and compare. A stalled result
// holds the byte in the input register, and in_ready follows out_ready combinationally while
// both registers are full. Uses wsd_pkg, wsd_parser and wsd_out_reg.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       has_data,
    output logic [3:0] message_opcode,
    output logic       last_of_frame,
    output logic       last_of_message,
    output logic [3:0] verdict
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       step;
    logic       res_valid;
    res_t       res;
    res_t       out_res;

    assign step     = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign data_byte       = out_res.data_byte;
    assign has_data        = out_res.has_data;
    assign message_opcode  = out_res.message_opcode;
    assign last_of_frame   = out_res.last_of_frame;
    assign last_of_message = out_res.last_of_message;
    assign verdict         = out_res.verdict;

endmodule

[test/tb_websocket_frame_deframer.sv]
// Self-checking testbench for websocket_frame_deframer: directed frames, random
// frame traffic under idling and back-pressure, and a final link shutdown.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam logic [3:0] PH_HDR0     = 4'd0;
    localparam logic [3:0] PH_HDR1     = 4'd1;
    localparam logic [3:0] PH_LEN64    = 4'd2;
    localparam logic [3:0] PH_LEN16    = 4'd8;
    localparam logic [3:0] PH_LEN_LAST = 4'd9;
    localparam logic [3:0] PH_KEY0     = 4'd10;
    localparam logic [3:0] PH_KEY_LAST = 4'd13;
    localparam logic [3:0] PH_DATA     = 4'd14;

    localparam int FORM_SHORT = 0;
    localparam int FORM_16    = 1;
    localparam int FORM_64    = 2;

    localparam int DRAIN_SLACK = 20;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] message_opcode;
    logic       last_of_frame;
    logic       last_of_message;
    logic [3:0] verdict;

    // deframer shadow state
    logic [3:0]  hdr_phase  = PH_HDR0;
    logic        cur_fin    = 1'b0;
    logic [3:0]  cur_op     = 4'd0;
    logic        cur_masked = 1'b0;
    logic [63:0] bytes_left = 64'd0;
    logic [31:0] cur_key    = 32'd0;
    logic [1:0]  key_idx    = 2'd0;
    logic [3:0]  held_op    = 4'd0;
    logic        frag_open  = 1'b0;
    logic        closed     = 1'b0;

    res_t expected_results[$];

    int    send_idle_pct  = 0;
    int    recv_idle_pct  = 0;
    int    hold_off_total = 0;
    int    hold_off_done  = 0;
    int    bytes_sent     = 0;
    int    mismatches     = 0;
    int    frames_checked = 0;
    int    payload_checked = 0;
    logic  gen_frag_open  = 1'b0;
    string shutdown_kind  = "none";

    websocket_frame_deframer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_byte       (data_byte),
        .has_data        (has_data),
        .message_opcode  (message_opcode),
        .last_of_frame   (last_of_frame),
        .last_of_message (last_of_message),
        .verdict         (verdict)
    );

    always #2 clk = ~clk;

    function automatic logic [3:0] verdict_for(input logic [3:0] op);
        case (op)
            OP_TEXT:  return VERDICT_TEXT;
            OP_BIN:   return VERDICT_BINARY;
            OP_CLOSE: return VERDICT_CLOSE;
            OP_PING:  return VERDICT_PING;
            OP_PONG:  return VERDICT_PONG;
            default:  return VERDICT_UNKNOWN;
        endcase
    endfunction

    task automatic end_of_frame(input logic [7:0] d, input logic has);
        logic [3:0] eff;
        res_t       r;
        eff = (cur_op != OP_CONT) ? cur_op : held_op;
        r = '0;
        r.data_byte       = has ? d : 8'h00;
        r.has_data        = has;
        r.message_opcode  = eff;
        r.last_of_frame   = 1'b1;
        r.last_of_message = cur_fin;
        r.verdict         = VERDICT_NONE;
        if (cur_fin)
        begin
            r.verdict = verdict_for(eff);
            frag_open = 1'b0;
            if (eff == OP_CLOSE)
                closed = 1'b1;
        end
        hdr_phase = PH_HDR0;
        expected_results.push_back(r);
    endtask

    task automatic header_complete();
        logic [3:0] err;
        res_t       r;
        hdr_phase = PH_HDR0;
        err = VERDICT_NONE;
        if (bytes_left > LEN_LIMIT)
            err = VERDICT_ERR_LEN;
        else if (cur_op != OP_CONT && frag_open)
            err = VERDICT_ERR_FRAG;
        else if (cur_op == OP_CONT && !frag_open)
            err = VERDICT_ERR_CONT;
        if (err != VERDICT_NONE)
        begin
            closed = 1'b1;
            r = '0;
            r.message_opcode  = cur_op;
            r.last_of_frame   = 1'b1;
            r.last_of_message = cur_fin;
            r.verdict         = err;
            expected_results.push_back(r);
        end
        else
        begin
            if (!cur_fin && cur_op != OP_CONT)
            begin
                held_op   = cur_op;
                frag_open = 1'b1;
            end
            if (bytes_left == 64'd0)
                end_of_frame(8'h00, 1'b0);
            else
                hdr_phase = PH_DATA;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] key_byte;
        logic [7:0] d;
        res_t       r;
        if (!closed)
        begin
            if (hdr_phase == PH_HDR0)
            begin
                cur_fin    = b[7];
                cur_op     = b[3:0];
                cur_key    = 32'd0;
                key_idx    = 2'd0;
                bytes_left = 64'd0;
                hdr_phase  = PH_HDR1;
            end
            else if (hdr_phase == PH_HDR1)
            begin
                cur_masked = b[7];
                if (b[6:0] < 7'd126)
                begin
                    bytes_left = {57'd0, b[6:0]};
                    if (cur_masked)
                        hdr_phase = PH_KEY0;
                    else
                        header_complete();
                end
                else
                    hdr_phase = (b[6:0] == 7'd126) ? PH_LEN16 : PH_LEN64;
            end
            else if (hdr_phase >= PH_LEN64 && hdr_phase <= PH_LEN_LAST)
            begin
                bytes_left = {bytes_left[55:0], b};
                if (hdr_phase == PH_LEN_LAST)
                begin
                    if (cur_masked)
                        hdr_phase = PH_KEY0;
                    else
                        header_complete();
                end
                else
                    hdr_phase = hdr_phase + 4'd1;
            end
            else if (hdr_phase >= PH_KEY0 && hdr_phase <= PH_KEY_LAST)
            begin
                cur_key = {cur_key[23:0], b};
                if (hdr_phase == PH_KEY_LAST)
                    header_complete();
                else
                    hdr_phase = hdr_phase + 4'd1;
            end
            else if (hdr_phase == PH_DATA)
            begin
                key_byte   = 8'(cur_key >> (24 - 8 * key_idx));
                d          = b ^ key_byte;
                key_idx    = key_idx + 2'd1;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 64'd0)
                    end_of_frame(d, 1'b1);
                else
                begin
                    r = '0;
                    r.data_byte      = d;
                    r.has_data       = 1'b1;
                    r.message_opcode = (cur_op != OP_CONT) ? cur_op : held_op;
                    expected_results.push_back(r);
                end
            end
            else
                hdr_phase = PH_HDR0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            deframe_byte(rx_byte);
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual data %0h verdict %0d",
                         $time, data_byte, verdict);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("data_byte", want.data_byte, data_byte);
                check_field("has_data", 8'(want.has_data), 8'(has_data));
                check_field("message_opcode", 8'(want.message_opcode), 8'(message_opcode));
                check_field("last_of_frame", 8'(want.last_of_frame), 8'(last_of_frame));
                check_field("last_of_message", 8'(want.last_of_message),
                            8'(last_of_message));
                check_field("verdict", 8'(want.verdict), 8'(verdict));
                if (want.last_of_frame)
                    frames_checked++;
                if (want.has_data)
                    payload_checked++;
            end
        end
    end

    // receiver: long hold-offs on request, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_off_done < hold_off_total)
        begin
            out_ready <= 1'b0;
            hold_off_done++;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input int form, input logic [63:0] len, input int n_payload);
        send_byte({fin, 3'($urandom), op});
        if (form == FORM_SHORT)
            send_byte({masked, len[6:0]});
        else if (form == FORM_16)
        begin
            send_byte({masked, 7'd126});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else
        begin
            send_byte({masked, 7'd127});
            for (int i = 7; i >= 0; i--)
                send_byte(len[8 * i +: 8]);
        end
        if (masked)
            repeat (4) send_byte(8'($urandom));
        repeat (n_payload) send_byte(8'($urandom));
        if (fin)
            gen_frag_open = 1'b0;
        else if (op != OP_CONT)
            gen_frag_open = 1'b1;
    endtask

    task automatic send_random_frame();
        logic        fin;
        logic [3:0]  op;
        logic        masked;
        logic [63:0] len;
        int          form;
        int          pick;
        if (gen_frag_open)
        begin
            op  = OP_CONT;
            fin = ($urandom_range(0, 2) == 0);
        end
        else
        begin
            fin  = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                op = OP_TEXT;
            else if (pick < 6)
                op = OP_BIN;
            else if (pick == 6)
                op = OP_PING;
            else if (pick == 7)
                op = OP_PONG;
            else if ($urandom_range(0, 1) == 0)
                op = 4'($urandom_range(3, 7));
            else
                op = 4'($urandom_range(11, 15));
        end
        masked = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 9);
        form   = (pick < 7) ? FORM_SHORT : (pick < 9) ? FORM_16 : FORM_64;
        len    = 64'($urandom_range(0, 12));
        if ($urandom_range(0, 19) == 0)
        begin
            if (form == FORM_SHORT)
                len = 64'd125;
            else if (form == FORM_16)
                len = 64'($urandom_range(126, 300));
            else
                len = 64'($urandom_range(0, 200));
        end
        send_frame(fin, op, masked, form, len, int'(len));
    endtask

    task automatic test_directed_frames();
        send_frame(1'b1, OP_TEXT, 1'b0, FORM_SHORT, 64'd1, 1);
        send_frame(1'b1, OP_BIN, 1'b1, FORM_16, 64'd2, 2);
        send_frame(1'b1, OP_PING, 1'b0, FORM_SHORT, 64'd0, 0);
        send_frame(1'b1, OP_PONG, 1'b1, FORM_SHORT, 64'd0, 0);
        send_frame(1'b0, OP_TEXT, 1'b0, FORM_SHORT, 64'd0, 0);
        send_frame(1'b1, OP_CONT, 1'b1, FORM_SHORT, 64'd1, 1);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_bytes, input int s_pct, input int r_pct);
        int stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_frame();
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_off_total = hold_off_total + 300;
        send_frame(1'b1, gen_frag_open ? OP_CONT : OP_BIN, 1'b1, FORM_16, 64'd150, 150);
        wait_drain();
    endtask

    task automatic test_link_shutdown();
        logic [63:0] len;
        send_idle_pct = 10;
        recv_idle_pct = 10;
        case ($urandom_range(0, 4))
            0:
            begin
                shutdown_kind = "close frame";
                if (gen_frag_open)
                    send_frame(1'b1, OP_CONT, 1'b0, FORM_SHORT, 64'd1, 1);
                send_frame(1'b1, OP_CLOSE, 1'($urandom_range(0, 1)), FORM_SHORT, 64'd2, 2);
            end
            1:
            begin
                shutdown_kind = "control frame inside fragmented message";
                if (!gen_frag_open)
                    send_frame(1'b0, OP_TEXT, 1'b1, FORM_SHORT, 64'd3, 3);
                send_frame(1'b1, OP_PING, 1'b0, FORM_SHORT, 64'd2, 2);
            end
            2:
            begin
                shutdown_kind = "continuation with no message open";
                if (gen_frag_open)
                    send_frame(1'b1, OP_CONT, 1'b0, FORM_SHORT, 64'd1, 1);
                send_frame(1'b1, OP_CONT, 1'b1, FORM_SHORT, 64'd4, 4);
            end
            3:
            begin
                shutdown_kind = "oversized payload length";
                len = {1'b1, 31'($urandom), 32'($urandom)};
                send_frame(1'($urandom_range(0, 1)), OP_BIN, 1'b1, FORM_64, len, 4);
            end
            default:
            begin
                shutdown_kind = "largest legal length, left open";
                if (gen_frag_open)
                    send_frame(1'b1, OP_CONT, 1'b0, FORM_SHORT, 64'd0, 0);
                send_frame(1'b1, OP_BIN, 1'b1, FORM_64, LEN_LIMIT, 40);
            end
        endcase
        repeat (16) send_byte(8'($urandom));
        wait_drain();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_frames();
        test_random_traffic(420, 25, 47);
        test_random_traffic(420, 47, 25);
        test_random_traffic(420, 0, 0);
        test_backpressure();
        test_link_shutdown();
        $display("Summary: %0d input bytes, %0d frames and %0d payload bytes checked",
                 bytes_sent, frames_checked, payload_checked);
        $display("Summary: stream ended by %s", shutdown_kind);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
